// ----- design/ecc_point_mul_add_prime_field_top_macros.svh -----
// Assertion helpers for the ECC point unit.
`ifndef ECC_POINT_MUL_ADD_PRIME_FIELD_TOP_MACROS_SVH
`define ECC_POINT_MUL_ADD_PRIME_FIELD_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ECPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ECPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ECPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ECPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/ecpm_pkg.sv -----
package ecpm_pkg;

  localparam int unsigned FIELD_BITS_DEF  = 16;
  localparam int unsigned SCALAR_BITS_DEF = 16;

  localparam logic [63:0] PRIME_RST   = 64'd23;
  localparam logic [63:0] COEFF_A_RST = 64'd1;

  // config register indexes
  localparam logic CFG_PRIME   = 1'b0;
  localparam logic CFG_COEFF_A = 1'b1;

  // item operation codes
  localparam logic OP_SCALAR_MUL = 1'b0;
  localparam logic OP_POINT_ADD  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_INV = 2'd1;
  localparam logic [1:0] STATUS_ZERO_N = 2'd2;

  typedef enum logic [1:0] {
    FU_RED,
    FU_MUL,
    FU_INV
  } fu_op_e;

  typedef enum logic [1:0] {
    FU_IDLE,
    FU_CHK,
    FU_DIV,
    FU_END
  } fu_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED_A,
    ST_RED_X1,
    ST_RED_Y1,
    ST_RED_X2,
    ST_RED_Y2,
    ST_ADD_INV,
    ST_ADD_M,
    ST_DBL_INV,
    ST_DBL_SQ,
    ST_DBL_3,
    ST_DBL_M,
    ST_FIN_SQ,
    ST_FIN_MY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic   start;
    fu_op_e op;
  } fu_req_t;

  typedef struct packed {
    logic done;
    logic err;
  } fu_rsp_t;

  // (a + b) mod p, a and b below p
  function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] p);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[63:0];
  endfunction

  // (a - b) mod p, a and b below p
  function automatic logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] p);
    logic [63:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (p - b);
    end
    return r;
  endfunction

endpackage

// ----- design/ecpm_fu.sv -----
// Bit-serial field unit: reduce, multiply, and inverse by extended Euclid.
// One quotient bit per cycle; multiply runs as a divide by one.
module ecpm_fu #(
  parameter int unsigned FIELD_BITS = ecpm_pkg::FIELD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ecpm_pkg::fu_req_t       req_i,
  input  logic [FIELD_BITS-1:0]   a_i,
  input  logic [FIELD_BITS-1:0]   b_i,
  input  logic [FIELD_BITS-1:0]   p_i,
  output ecpm_pkg::fu_rsp_t       rsp_o,
  output logic [FIELD_BITS-1:0]   res_o
);
  import ecpm_pkg::*;

  localparam int unsigned CntW = $clog2(FIELD_BITS + 1);
  localparam int unsigned FB   = FIELD_BITS;

  fu_state_e       state_q, state_d;
  fu_op_e          op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [FB-1:0]   dv_q, dv_d, dvs_q, dvs_d, rem_q, rem_d, acc_q, acc_d, mc_q, mc_d;
  logic [FB-1:0]   r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  logic [FB-1:0]   res_q, res_d;
  logic            done_q, done_d, err_q, err_d;
  logic [FB:0]     rem2;
  logic            qbit;
  logic [FB-1:0]   acc_dbl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cnt_q <= cnt_d;
    dv_q  <= dv_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    mc_q  <= mc_d;
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    t0_q  <= t0_d;
    t1_q  <= t1_d;
    res_q <= res_d;
    err_q <= err_d;
  end

  // one restoring-divide step, quotient bit folded into acc = q * mc mod p
  assign rem2    = {rem_q, dv_q[FB-1]};
  assign qbit    = rem2 >= {1'b0, dvs_q};
  assign acc_dbl = FB'(mod_add(64'(acc_q), 64'(acc_q), 64'(p_i)));

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    dv_d    = dv_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    mc_d    = mc_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    res_d   = res_q;
    err_d   = err_q;
    done_d  = 1'b0;
    case (state_q)
      FU_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          rem_d = '0;
          acc_d = '0;
          cnt_d = CntW'(FB);
          err_d = 1'b0;
          case (req_i.op)
            FU_RED: begin
              dv_d    = a_i;
              dvs_d   = p_i;
              mc_d    = '0;
              state_d = FU_DIV;
            end
            FU_MUL: begin
              dv_d    = b_i;
              dvs_d   = FB'(1);
              mc_d    = a_i;
              state_d = FU_DIV;
            end
            FU_INV: begin
              r0_d    = p_i;
              r1_d    = a_i;
              t0_d    = '0;
              t1_d    = FB'(1);
              state_d = FU_CHK;
            end
            default: state_d = FU_IDLE;
          endcase
        end
      end
      FU_CHK: begin
        if (r1_q == '0) begin
          res_d   = t0_q;
          err_d   = (r0_q != FB'(1));
          done_d  = 1'b1;
          state_d = FU_IDLE;
        end else begin
          dv_d    = r0_q;
          dvs_d   = r1_q;
          mc_d    = t1_q;
          rem_d   = '0;
          acc_d   = '0;
          cnt_d   = CntW'(FB);
          state_d = FU_DIV;
        end
      end
      FU_DIV: begin
        rem_d = qbit ? FB'(rem2 - {1'b0, dvs_q}) : FB'(rem2);
        dv_d  = dv_q << 1;
        acc_d = FB'(mod_add(64'(acc_dbl), qbit ? 64'(mc_q) : 64'(0), 64'(p_i)));
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = FU_END;
        end
      end
      FU_END: begin
        case (op_q)
          FU_RED: begin
            res_d   = rem_q;
            done_d  = 1'b1;
            state_d = FU_IDLE;
          end
          FU_MUL: begin
            res_d   = acc_q;
            done_d  = 1'b1;
            state_d = FU_IDLE;
          end
          FU_INV: begin
            r0_d    = r1_q;
            r1_d    = rem_q;
            t0_d    = t1_q;
            t1_d    = FB'(mod_sub(64'(t0_q), 64'(acc_q), 64'(p_i)));
            state_d = FU_CHK;
          end
          default: state_d = FU_IDLE;
        endcase
      end
      default: state_d = FU_IDLE;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.err  = err_q;
  assign res_o      = res_q;

endmodule

// ----- design/ecc_point_mul_add_prime_field_top.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | operation, scalar, first_x/y, second_x/y
// out     | output    | out_valid_o/out_stall_i | result_x, result_y, status
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item at a time. Each field op is bit-serial in the shared field unit:
// reduce and multiply are each one divide pass, an inverse is one divide
// pass per Euclid step, up to ~1.5*FIELD_BITS steps.
// Point add ~ one inverse + 3 multiplies, doubling ~ one inverse + 5;
// scalar multiply ~ one doubling + (n-2) adds.
// Reset: async active low; p = 23, a = 1. Output register holds a finished
// item while the next one is taken; a new result waits if it is full and stalled.
`include "ecc_point_mul_add_prime_field_top_macros.svh"

module ecc_point_mul_add_prime_field_top #(
  parameter int unsigned FIELD_BITS  = ecpm_pkg::FIELD_BITS_DEF,
  parameter int unsigned SCALAR_BITS = ecpm_pkg::SCALAR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [FIELD_BITS-1:0]  cfg_data_i,
  // items in
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   in_operation_i,
  input  logic [SCALAR_BITS-1:0] in_scalar_i,
  input  logic [FIELD_BITS-1:0]  in_first_x_i,
  input  logic [FIELD_BITS-1:0]  in_first_y_i,
  input  logic [FIELD_BITS-1:0]  in_second_x_i,
  input  logic [FIELD_BITS-1:0]  in_second_y_i,
  // results out
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [FIELD_BITS-1:0]  out_result_x_o,
  output logic [FIELD_BITS-1:0]  out_result_y_o,
  output logic [1:0]             out_status_o
);
  import ecpm_pkg::*;

  localparam int unsigned FB = FIELD_BITS;
  localparam int unsigned SB = SCALAR_BITS;

  // config registers
  logic [FB-1:0] p_q, coef_q;

  // item state
  state_e        state_q, state_d;
  logic          wait_q, wait_d;
  logic          op_q, op_d;
  logic [SB-1:0] cnt_q, cnt_d;          // scalar, then adds left
  logic [1:0]    status_q, status_d;
  // G = (gx, gy); H = second point, later running result
  logic [FB-1:0] gx_q, gx_d, gy_q, gy_d, hx_q, hx_d, hy_q, hy_d;
  logic [FB-1:0] ar_q, ar_d;            // a mod p
  logic [FB-1:0] t_q, t_d, u_q, u_d, m_q, m_d;

  // output register
  logic          ovld_q, ovld_d;
  logic [FB-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [1:0]    ost_q, ost_d;

  // field unit
  fu_req_t       fu_req;
  fu_rsp_t       fu_rsp;
  logic          fu_start;
  logic [FB-1:0] fu_a, fu_b, fu_res;
  logic [FB-1:0] three_mod;

  ecpm_fu #(
    .FIELD_BITS(FIELD_BITS)
  ) u_fu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (fu_req),
    .a_i   (fu_a),
    .b_i   (fu_b),
    .p_i   (p_q),
    .rsp_o (fu_rsp),
    .res_o (fu_res)
  );

  function automatic logic [FB-1:0] fadd(logic [FB-1:0] a, logic [FB-1:0] b,
                                         logic [FB-1:0] p);
    return FB'(mod_add(64'(a), 64'(b), 64'(p)));
  endfunction

  function automatic logic [FB-1:0] fsub(logic [FB-1:0] a, logic [FB-1:0] b,
                                         logic [FB-1:0] p);
    return FB'(mod_sub(64'(a), 64'(b), 64'(p)));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q     <= PRIME_RST[FB-1:0];
      coef_q  <= COEFF_A_RST[FB-1:0];
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRIME:   p_q    <= cfg_data_i;
          CFG_COEFF_A: coef_q <= cfg_data_i;
          default:     p_q    <= p_q;
        endcase
      end
      state_q <= state_d;
      wait_q  <= wait_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    gx_q     <= gx_d;
    gy_q     <= gy_d;
    hx_q     <= hx_d;
    hy_q     <= hy_d;
    ar_q     <= ar_d;
    t_q      <= t_d;
    u_q      <= u_d;
    m_q      <= m_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    ost_q    <= ost_d;
  end

  // 3 mod p for p >= 2
  assign three_mod = (p_q == FB'(2)) ? FB'(1) : ((p_q == FB'(3)) ? '0 : FB'(3));

  assign in_stall_o = (state_q != ST_IDLE);

  assign fu_start = !wait_q && (state_q inside {ST_RED_A, ST_RED_X1, ST_RED_Y1,
                    ST_RED_X2, ST_RED_Y2, ST_ADD_INV, ST_ADD_M, ST_DBL_INV,
                    ST_DBL_SQ, ST_DBL_3, ST_DBL_M, ST_FIN_SQ, ST_FIN_MY});

  // field unit operands per step
  always_comb begin
    fu_req.start = fu_start;
    fu_req.op    = FU_MUL;
    fu_a         = '0;
    fu_b         = '0;
    case (state_q)
      ST_RED_A:   begin fu_req.op = FU_RED; fu_a = coef_q; end
      ST_RED_X1:  begin fu_req.op = FU_RED; fu_a = gx_q;   end
      ST_RED_Y1:  begin fu_req.op = FU_RED; fu_a = gy_q;   end
      ST_RED_X2:  begin fu_req.op = FU_RED; fu_a = hx_q;   end
      ST_RED_Y2:  begin fu_req.op = FU_RED; fu_a = hy_q;   end
      ST_ADD_INV: begin fu_req.op = FU_INV; fu_a = fsub(hx_q, gx_q, p_q); end
      ST_ADD_M:   begin fu_a = fsub(hy_q, gy_q, p_q); fu_b = t_q; end
      ST_DBL_INV: begin fu_req.op = FU_INV; fu_a = fadd(gy_q, gy_q, p_q); end
      ST_DBL_SQ:  begin fu_a = gx_q; fu_b = gx_q; end
      ST_DBL_3:   begin fu_a = u_q;  fu_b = three_mod; end
      ST_DBL_M:   begin fu_a = fadd(u_q, ar_q, p_q); fu_b = t_q; end
      ST_FIN_SQ:  begin fu_a = m_q;  fu_b = m_q; end
      ST_FIN_MY:  begin fu_a = m_q;  fu_b = fsub(gx_q, t_q, p_q); end
      default:    fu_req.op = FU_MUL;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    wait_d   = wait_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    gx_d     = gx_q;
    gy_d     = gy_q;
    hx_d     = hx_q;
    hy_d     = hy_q;
    ar_d     = ar_q;
    t_d      = t_q;
    u_d      = u_q;
    m_d      = m_q;
    ovld_d   = ovld_q && out_stall_i;
    ox_d     = ox_q;
    oy_d     = oy_q;
    ost_d    = ost_q;

    if (fu_start) begin
      wait_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_operation_i;
          cnt_d   = in_scalar_i;
          gx_d    = in_first_x_i;
          gy_d    = in_first_y_i;
          hx_d    = in_second_x_i;
          hy_d    = in_second_y_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        status_d = STATUS_OK;
        if (op_q == OP_SCALAR_MUL && cnt_q == '0) begin
          status_d = STATUS_ZERO_N;
          state_d  = ST_DONE;
        end else if (p_q < FB'(2)) begin
          status_d = STATUS_NO_INV;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_RED_A;
        end
      end
      ST_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d  = 1'b1;
          ost_d   = status_q;
          ox_d    = (status_q == STATUS_OK) ? hx_q : '0;
          oy_d    = (status_q == STATUS_OK) ? hy_q : '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        if (fu_rsp.done) begin
          wait_d = 1'b0;
          case (state_q)
            ST_RED_A: begin
              ar_d    = fu_res;
              state_d = ST_RED_X1;
            end
            ST_RED_X1: begin
              gx_d    = fu_res;
              state_d = ST_RED_Y1;
            end
            ST_RED_Y1: begin
              gy_d = fu_res;
              if (op_q == OP_POINT_ADD) begin
                state_d = ST_RED_X2;
              end else if (cnt_q == SB'(1)) begin
                // n = 1: the reduced base point itself
                hx_d    = gx_q;
                hy_d    = fu_res;
                state_d = ST_DONE;
              end else begin
                hx_d    = gx_q;     // doubling: second point is G
                cnt_d   = cnt_q - SB'(2);
                state_d = ST_DBL_INV;
              end
            end
            ST_RED_X2: begin
              hx_d    = fu_res;
              state_d = ST_RED_Y2;
            end
            ST_RED_Y2: begin
              hy_d    = fu_res;
              state_d = ST_ADD_INV;
            end
            ST_ADD_INV, ST_DBL_INV: begin
              t_d = fu_res;
              if (fu_rsp.err) begin
                status_d = STATUS_NO_INV;
                state_d  = ST_DONE;
              end else begin
                state_d = (state_q == ST_ADD_INV) ? ST_ADD_M : ST_DBL_SQ;
              end
            end
            ST_ADD_M: begin
              m_d     = fu_res;
              state_d = ST_FIN_SQ;
            end
            ST_DBL_SQ: begin
              u_d     = fu_res;
              state_d = ST_DBL_3;
            end
            ST_DBL_3: begin
              u_d     = fu_res;
              state_d = ST_DBL_M;
            end
            ST_DBL_M: begin
              m_d     = fu_res;
              state_d = ST_FIN_SQ;
            end
            ST_FIN_SQ: begin
              // x3 = m^2 - px - qx
              t_d     = fsub(fsub(fu_res, gx_q, p_q), hx_q, p_q);
              state_d = ST_FIN_MY;
            end
            ST_FIN_MY: begin
              hx_d = t_q;
              hy_d = fsub(fu_res, gy_q, p_q);
              if (op_q == OP_SCALAR_MUL && cnt_q != '0) begin
                cnt_d   = cnt_q - SB'(1);
                state_d = ST_ADD_INV;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  assign out_valid_o    = ovld_q;
  assign out_result_x_o = ox_q;
  assign out_result_y_o = oy_q;
  assign out_status_o   = ost_q;

  // field unit only answers a request the sequencer is waiting on
  `ECPM_ASSERT_IMP(a_fu_done_waited, clk_i, rst_ni, fu_rsp.done, wait_q)
  // an accepted item blocks the input until it is finished
  `ECPM_ASSERT_NXT(a_accept_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // any error status carries a zero point
  `ECPM_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && out_status_o != STATUS_OK,
                   out_result_x_o == '0 && out_result_y_o == '0)

endmodule

// ----- tb/ecpm_result_checker.sv -----
`timescale 1ns / 1ps

module ecpm_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        in_operation_i,
  input  logic [15:0] in_scalar_i,
  input  logic [15:0] in_first_x_i,
  input  logic [15:0] in_first_y_i,
  input  logic [15:0] in_second_x_i,
  input  logic [15:0] in_second_y_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] out_result_x_i,
  input  logic [15:0] out_result_y_i,
  input  logic [1:0]  out_status_i,
  output int          fail_count_o,
  output int          pending_o
);
  import ecpm_pkg::*;

  typedef logic [63:0] fe_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [1:0]  status;
  } point_res_t;

  fe_t modulus_q, coeff_a_q;
  point_res_t expected_points[$];

  function automatic fe_t fsub(fe_t a, fe_t b, fe_t p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  function automatic fe_t fmul(fe_t a, fe_t b, fe_t p);
    return (a * b) % p;
  endfunction

  // extended Euclid; fails when gcd(a, p) != 1
  function automatic bit finv(fe_t a, fe_t p, output fe_t inv);
    fe_t r0, r1, r2, t0, t1, t2, q;
    r0 = p; r1 = a; t0 = 0; t1 = 1 % p;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = fsub(t0, fmul(q % p, t1, p), p);
      r0 = r1; r1 = r2;
      t0 = t1; t1 = t2;
    end
    inv = t0;
    return r0 == 1;
  endfunction

  function automatic void chord(fe_t m, fe_t px, fe_t py, fe_t qx, fe_t p,
                                output fe_t rx, output fe_t ry);
    fe_t x3;
    x3 = fsub(fsub(fmul(m, m, p), px, p), qx, p);
    ry = fsub(fmul(m, fsub(px, x3, p), p), py, p);
    rx = x3;
  endfunction

  function automatic bit pt_add(fe_t px, fe_t py, fe_t qx, fe_t qy, fe_t p,
                                output fe_t rx, output fe_t ry);
    fe_t inv;
    rx = 0; ry = 0;
    if (!finv(fsub(qx, px, p), p, inv)) return 0;
    chord(fmul(fsub(qy, py, p), inv, p), px, py, qx, p, rx, ry);
    return 1;
  endfunction

  function automatic bit pt_double(fe_t gx, fe_t gy, fe_t a, fe_t p,
                                   output fe_t rx, output fe_t ry);
    fe_t inv, num;
    rx = 0; ry = 0;
    if (!finv((gy + gy) % p, p, inv)) return 0;
    num = (fmul(3 % p, fmul(gx, gx, p), p) + a) % p;
    chord(fmul(num, inv, p), gx, gy, gx, p, rx, ry);
    return 1;
  endfunction

  function automatic point_res_t predict_point(logic op, fe_t n, fe_t fx, fe_t fy,
                                               fe_t sx, fe_t sy);
    point_res_t r;
    fe_t p, a, x1, y1, rx, ry, tx, ty;
    bit ok;
    p = modulus_q; rx = 0; ry = 0; ok = 1;
    r.status = STATUS_OK;
    if (op == OP_SCALAR_MUL && n == 0) begin
      r.status = STATUS_ZERO_N;
    end else if (p < 2) begin
      r.status = STATUS_NO_INV;
    end else begin
      a = coeff_a_q % p; x1 = fx % p; y1 = fy % p;
      if (op == OP_POINT_ADD) begin
        ok = pt_add(x1, y1, sx % p, sy % p, p, rx, ry);
      end else if (n == 1) begin
        rx = x1; ry = y1;
      end else begin
        ok = pt_double(x1, y1, a, p, rx, ry);
        for (fe_t k = 3; ok && k <= n; k++) begin
          ok = pt_add(x1, y1, rx, ry, p, tx, ty);
          rx = tx; ry = ty;
        end
      end
      if (!ok) begin
        rx = 0; ry = 0;
        r.status = STATUS_NO_INV;
      end
    end
    r.x = rx[15:0];
    r.y = ry[15:0];
    return r;
  endfunction

  assign pending_o = expected_points.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_res_t exp_r;
    if (!rst_ni) begin
      modulus_q    <= PRIME_RST;
      coeff_a_q    <= COEFF_A_RST;
      fail_count_o <= 0;
      expected_points.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PRIME) modulus_q <= fe_t'(cfg_data_i);
        else coeff_a_q <= fe_t'(cfg_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        expected_points.push_back(predict_point(in_operation_i, fe_t'(in_scalar_i),
          fe_t'(in_first_x_i), fe_t'(in_first_y_i), fe_t'(in_second_x_i),
          fe_t'(in_second_y_i)));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result x=%0d y=%0d st=%0d",
                                          out_result_x_i, out_result_y_i, out_status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_points.pop_front();
          if (exp_r.x !== out_result_x_i || exp_r.y !== out_result_y_i ||
              exp_r.status !== out_status_i) begin
            if (fail_count_o < 10)
              $display("mismatch: exp x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d",
                       exp_r.x, exp_r.y, exp_r.status,
                       out_result_x_i, out_result_y_i, out_status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ecpm_pkg::*;

  localparam int IDLE_LIMIT = 100000;

  logic        clk, rst_n;
  logic        cfg_we, cfg_idx;
  logic [15:0] cfg_data;
  logic        in_valid, in_stall, in_op;
  logic [15:0] in_n, in_fx, in_fy, in_sx, in_sy;
  logic        out_valid, out_stall;
  logic [15:0] out_x, out_y;
  logic [1:0]  out_status;
  int          fail_count, pending;
  int          tx_pct, rx_pct, idle_cycles;
  logic [15:0] cur_p;

  // 100 MHz clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  ecc_point_mul_add_prime_field_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_operation_i (in_op),
    .in_scalar_i    (in_n),
    .in_first_x_i   (in_fx),
    .in_first_y_i   (in_fy),
    .in_second_x_i  (in_sx),
    .in_second_y_i  (in_sy),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_result_x_o (out_x),
    .out_result_y_o (out_y),
    .out_status_o   (out_status)
  );

  ecpm_result_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_operation_i (in_op),
    .in_scalar_i    (in_n),
    .in_first_x_i   (in_fx),
    .in_first_y_i   (in_fy),
    .in_second_x_i  (in_sx),
    .in_second_y_i  (in_sy),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_result_x_i (out_x),
    .out_result_y_i (out_y),
    .out_status_i   (out_status),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  // watchdog: cycles without any item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // hold valid until the item is taken; sender gaps at random before it
  task automatic send_item(logic op, logic [15:0] n, logic [15:0] fx, logic [15:0] fy,
                           logic [15:0] sx, logic [15:0] sy);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_n     <= n;
    in_fx    <= fx;
    in_fy    <= fy;
    in_sx    <= sx;
    in_sy    <= sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain everything in flight, then write one register
  task automatic write_reg(logic idx, logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_PRIME) cur_p = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord();
    if (cur_p > 1 && $urandom_range(1)) return 16'($urandom_range(cur_p - 1));
    return 16'($urandom_range(16'hffff));
  endfunction

  // Random points are mostly off the curve, so a long add chain need not
  // stop early; full-range scalars only where the item ends at once.
  function automatic logic [15:0] rand_scalar();
    if ($urandom_range(9) == 0) return 16'd0;
    if (cur_p < 2)
      return 16'($urandom_range(16'hffff));
    return 16'($urandom_range(20));
  endfunction

  task automatic send_random();
    logic [15:0] fx, fy;
    fx = rand_coord();
    fy = rand_coord();
    if ($urandom_range(1)) begin
      // equal x coordinates now and then
      send_item(OP_POINT_ADD, 16'($urandom_range(16'hffff)), fx, fy,
                ($urandom_range(5) == 0) ? fx : rand_coord(), rand_coord());
    end else begin
      send_item(OP_SCALAR_MUL, rand_scalar(), fx, fy,
                16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)));
    end
  endtask

  initial begin
    logic [15:0] primes [6];
    logic [15:0] coeffs [6];
    primes = '{16'd23, 16'd65521, 16'd29, 16'd3, 16'd65535, 16'd97};
    coeffs = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd7, 16'd12345};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = CFG_PRIME; cfg_data = '0;
    in_valid = 1'b0; in_op = OP_SCALAR_MUL;
    in_n = '0; in_fx = '0; in_fy = '0; in_sx = '0; in_sy = '0;
    out_stall = 1'b0; idle_cycles = 0; cur_p = 16'd23;
    tx_pct = 35; rx_pct = 57;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings p = 23, a = 1
    send_item(OP_SCALAR_MUL, 16'd0, 16'd3, 16'd10, 16'd0, 16'd0);      // scalar zero
    send_item(OP_SCALAR_MUL, 16'd1, 16'hffff, 16'hffff, 16'd0, 16'd0);  // scalar one
    send_item(OP_SCALAR_MUL, 16'd2, 16'd3, 16'd10, 16'd0, 16'd0);
    send_item(OP_SCALAR_MUL, 16'd7, 16'd3, 16'd10, 16'd0, 16'd0);
    send_item(OP_SCALAR_MUL, 16'd2, 16'd5, 16'd23, 16'd0, 16'd0);       // 2y = 0 on doubling
    send_item(OP_SCALAR_MUL, 16'hffff, 16'd3, 16'd10, 16'd0, 16'd0);
    send_item(OP_POINT_ADD, 16'd0, 16'd3, 16'd10, 16'd9, 16'd7);
    send_item(OP_POINT_ADD, 16'hffff, 16'd3, 16'd10, 16'd3, 16'd10);    // P + P
    send_item(OP_POINT_ADD, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0);
    // modulus below two, then p = 2
    write_reg(CFG_PRIME, 16'd0);
    send_item(OP_POINT_ADD, 16'd0, 16'd1, 16'd2, 16'd3, 16'd4);
    send_item(OP_SCALAR_MUL, 16'd0, 16'd1, 16'd2, 16'd0, 16'd0);
    send_item(OP_SCALAR_MUL, 16'd5, 16'd1, 16'd2, 16'd0, 16'd0);
    write_reg(CFG_PRIME, 16'd1);
    send_item(OP_SCALAR_MUL, 16'hffff, 16'd1, 16'd2, 16'd0, 16'd0);
    write_reg(CFG_PRIME, 16'd2);
    send_item(OP_SCALAR_MUL, 16'd3, 16'd1, 16'd1, 16'd0, 16'd0);
    // largest prime, a at its top value; doubling fails at once on y = 0
    write_reg(CFG_PRIME, 16'd65521);
    write_reg(CFG_COEFF_A, 16'hffff);
    send_item(OP_SCALAR_MUL, 16'hffff, 16'd1234, 16'd65521, 16'd0, 16'd0);
    send_item(OP_SCALAR_MUL, 16'h8000, 16'd4321, 16'd0, 16'd0, 16'd0);
    send_item(OP_SCALAR_MUL, 16'd3, 16'd1234, 16'd777, 16'd0, 16'd0);
    send_item(OP_POINT_ADD, 16'd0, 16'd65520, 16'd1, 16'd1, 16'd65520);
    // composite modulus: shared-factor denominators
    write_reg(CFG_PRIME, 16'd15);
    send_item(OP_POINT_ADD, 16'd0, 16'd1, 16'd2, 16'd4, 16'd8);
    send_item(OP_SCALAR_MUL, 16'd4, 16'd2, 16'd1, 16'd0, 16'd0);

    // random part: six settings, idling pattern moves through the phases
    for (int s = 0; s < 6; s++) begin
      write_reg(CFG_PRIME, primes[s]);
      write_reg(CFG_COEFF_A, coeffs[s]);
      if (s < 2) begin
        tx_pct = 35; rx_pct = 57;
      end else if (s < 4) begin
        tx_pct = 57; rx_pct = 35;
      end else begin
        tx_pct = 0; rx_pct = 0;
      end
      for (int i = 0; i < 14; i++) send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ecpm_pkg.sv
design/ecpm_fu.sv
design/ecc_point_mul_add_prime_field_top.sv
tb/ecpm_result_checker.sv
tb/tb_top.sv
